// ===== hw/rtl/bsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants of the byte-stuffing framer.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  localparam logic [7:0] FLAG_RESET   = 8'd36;
  localparam logic [7:0] ESCAPE_RESET = 8'd47;

  typedef enum logic {
    REG_FLAG   = 1'b0,
    REG_ESCAPE = 1'b1
  } bsf_reg_t;

  // Expanded result bytes of one input byte.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            count;
    logic                        trailer;
  } bsf_slot_t;

endpackage

// ===== hw/rtl/byte_stuff_framer_xor_parity.sv =====
// ----------------------------------------------------------------------------
// byte_stuff_framer_xor_parity
// Byte-stuffing framer with flag, escape and XOR parity trailer.
// ----------------------------------------------------------------------------
// Path: input register, then result register, then the output port.
// Throughput: one output byte per cycle while m_tready is high; an input
// byte expands to 1 to 5 result bytes, one output transfer each.
// Input register and result register give one item of slack between sides.
// Reset (rst, synchronous) closes any frame, clears parity and restores
// flag 0x24 and escape 0x2F.
module byte_stuff_framer_xor_parity (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser,   // is_trailer
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]         flag_byte;
  logic [7:0]         escape_byte;
  logic               slot_valid;
  logic               slot_ready;
  bsf_pkg::bsf_slot_t slot;

  bsf_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .flag_byte   (flag_byte),
    .escape_byte (escape_byte)
  );

  bsf_expand u_expand (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .flag_byte   (flag_byte),
    .escape_byte (escape_byte),
    .slot_ready  (slot_ready),
    .slot_valid  (slot_valid),
    .slot        (slot)
  );

  bsf_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot_in    (slot),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

// ===== hw/rtl/bsf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bsf_cfg_regs
// APB register file holding the flag and escape byte values.
// ----------------------------------------------------------------------------
module bsf_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  flag_byte,
  output logic [7:0]  escape_byte
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte   <= bsf_pkg::FLAG_RESET;
      escape_byte <= bsf_pkg::ESCAPE_RESET;
    end else if (wr_en) begin
      unique case (bsf_pkg::bsf_reg_t'(paddr[2]))
        bsf_pkg::REG_FLAG:   flag_byte   <= pwdata[7:0];
        bsf_pkg::REG_ESCAPE: escape_byte <= pwdata[7:0];
        default:             flag_byte   <= flag_byte;
      endcase
    end
  end

  always_comb begin
    unique case (bsf_pkg::bsf_reg_t'(paddr[2]))
      bsf_pkg::REG_FLAG:   prdata = {24'd0, flag_byte};
      bsf_pkg::REG_ESCAPE: prdata = {24'd0, escape_byte};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/bsf_expand.sv =====
// ----------------------------------------------------------------------------
// bsf_expand
// Input register, frame state and expansion of one byte into its results.
// ----------------------------------------------------------------------------
module bsf_expand (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                s_tlast,   // end_of_message
  input  logic [7:0]          flag_byte,
  input  logic [7:0]          escape_byte,
  input  logic                slot_ready,
  output logic                slot_valid,
  output bsf_pkg::bsf_slot_t  slot
);

  logic                      in_valid;
  logic [7:0]                in_data;
  logic                      in_last;
  logic                      in_frame;
  logic [7:0]                parity_accum;
  logic                      load;
  logic [7:0]                parity_next;
  logic [bsf_pkg::CNT_W-1:0] n;
  logic [7:0]                p;

  assign load       = in_valid && slot_ready;
  assign s_tready   = !in_valid || load;
  assign slot_valid = in_valid;

  always_comb begin
    slot = '0;
    n    = '0;
    p    = parity_accum;
    if (!in_frame) begin
      slot.bytes[n[bsf_pkg::IDX_W-1:0]] = flag_byte;
      p = p ^ flag_byte;
      n = n + 1'b1;
    end
    if (in_data == flag_byte || in_data == escape_byte) begin
      slot.bytes[n[bsf_pkg::IDX_W-1:0]] = escape_byte;
      p = p ^ escape_byte;
      n = n + 1'b1;
    end
    slot.bytes[n[bsf_pkg::IDX_W-1:0]] = in_data;
    p = p ^ in_data;
    n = n + 1'b1;
    parity_next = p;
    if (in_last) begin
      slot.bytes[n[bsf_pkg::IDX_W-1:0]] = flag_byte;
      p = p ^ flag_byte;
      n = n + 1'b1;
      slot.bytes[n[bsf_pkg::IDX_W-1:0]] = p;
      n = n + 1'b1;
    end
    slot.count   = n;
    slot.trailer = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      in_frame     <= 1'b0;
      parity_accum <= 8'd0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (load) begin
        in_valid <= 1'b0;
      end
      if (load) begin
        in_frame     <= !in_last;
        parity_accum <= in_last ? 8'd0 : parity_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

endmodule

// ===== hw/rtl/bsf_emitter.sv =====
// ----------------------------------------------------------------------------
// bsf_emitter
// Result register: sends the expanded bytes of one item, one per transfer.
// ----------------------------------------------------------------------------
module bsf_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                slot_valid,
  output logic                slot_ready,
  input  bsf_pkg::bsf_slot_t  slot_in,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] out_byte
  output logic                m_tlast,   // last_of_run
  output logic                m_tuser    // is_trailer
);

  bsf_pkg::bsf_slot_t        slot;
  logic                      held;
  logic [bsf_pkg::IDX_W-1:0] idx;
  logic [bsf_pkg::CNT_W-1:0] last_idx;
  logic                      at_last;
  logic                      done;
  logic                      load;

  assign last_idx   = slot.count - 1'b1;
  assign at_last    = (idx == last_idx[bsf_pkg::IDX_W-1:0]);
  assign done       = held && m_tready && at_last;
  assign slot_ready = !held || done;
  assign load       = slot_valid && slot_ready;

  assign m_tvalid = held;
  assign m_tdata  = slot.bytes[idx];
  assign m_tlast  = at_last;
  assign m_tuser  = at_last && slot.trailer;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      held <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      held <= 1'b0;
    end else if (held && m_tready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= slot_in;
    end
  end

endmodule

// ===== hw/rtl/bsf_checker.sv =====
// ----------------------------------------------------------------------------
// bsf_checker
// Port-level checks of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic       m_tlast,
  input logic       m_tuser,
  input logic       pready
);

  // trailer always ends the run of its input byte
  a_trailer_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("trailer transfer without tlast");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

endmodule

bind byte_stuff_framer_xor_parity bsf_checker u_bsf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser),
  .pready   (pready)
);

// ===== sim/byte_stuff_framer_xor_parity_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuff_framer_xor_parity_tb
// Self-checking bench for the byte-stuffing framer with XOR parity trailer.
// A table of directed message bytes and register writes runs first. Frames
// of random length and content follow under several idle/stall mixes and one
// long output hold-off. Every output transfer is checked against a local
// framing predictor or the expected bytes of its directed row.
// ----------------------------------------------------------------------------
module byte_stuff_framer_xor_parity_tb;

  localparam int WDOG_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 6;
  localparam int PHASE_ITEMS = 16;
  localparam int N_PHASES    = 5;
  localparam int HOLD_CYCLES = 150;
  localparam int N_DIR       = 27;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       trailer;
    logic       run_end;
  } framed_byte_t;

  typedef struct {
    row_kind_t         kind;
    bsf_pkg::bsf_reg_t rsel;
    logic [7:0]        val;
    logic              eom;
    int                n_exp;
    logic [0:4][7:0]   exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic        s_tlast = 1'b0; // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] out_byte
  logic        m_tlast;        // last_of_run
  logic        m_tuser;        // is_trailer
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  byte_stuff_framer_xor_parity u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]   tb_flag = bsf_pkg::FLAG_RESET;
  logic [7:0]   tb_esc  = bsf_pkg::ESCAPE_RESET;
  logic         tb_open = 1'b0;
  logic [7:0]   tb_par  = '0;
  framed_byte_t framed_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  framed_byte_t got_exp;

  int phase_idle  [N_PHASES] = '{0, 73, 0, 9, 0};
  int phase_stall [N_PHASES] = '{0, 0, 73, 9, 0};

  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h41, 1'b1, 4, {8'h24, 8'h41, 8'h24, 8'h41, 8'h00}},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h24, 1'b1, 5, {8'h24, 8'h2F, 8'h24, 8'h24, 8'h0B}},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h2F, 1'b1, 5, {8'h24, 8'h2F, 8'h2F, 8'h24, 8'h00}},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h00, 1'b1, 4, {8'h24, 8'h00, 8'h24, 8'h00, 8'h00}},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'hFF, 1'b1, 4, {8'h24, 8'hFF, 8'h24, 8'hFF, 8'h00}},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h10, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h24, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h2F, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h55, 1'b1, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'hAA, 1'b0, 0, '0},
    // new values while a frame is open
    '{ROW_WRITE, bsf_pkg::REG_FLAG,   8'h00, 1'b0, 0, '0},
    '{ROW_WRITE, bsf_pkg::REG_ESCAPE, 8'hFF, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h00, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'hFF, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h24, 1'b1, 0, '0},
    // flag equal to escape: single escape
    '{ROW_WRITE, bsf_pkg::REG_FLAG,   8'h7E, 1'b0, 0, '0},
    '{ROW_WRITE, bsf_pkg::REG_ESCAPE, 8'h7E, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h7E, 1'b1, 5, {8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h00}},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h7D, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h7E, 1'b1, 0, '0},
    '{ROW_WRITE, bsf_pkg::REG_FLAG,   8'hFF, 1'b0, 0, '0},
    '{ROW_WRITE, bsf_pkg::REG_ESCAPE, 8'h00, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h80, 1'b1, 4, {8'hFF, 8'h80, 8'hFF, 8'h80, 8'h00}},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'h00, 1'b0, 0, '0},
    '{ROW_ITEM,  bsf_pkg::REG_FLAG,   8'hFF, 1'b1, 0, '0},
    '{ROW_WRITE, bsf_pkg::REG_FLAG,   8'h24, 1'b0, 0, '0},
    '{ROW_WRITE, bsf_pkg::REG_ESCAPE, 8'h2F, 1'b0, 0, '0}
  };

  task automatic frame_byte(input logic [7:0] d, input logic eom,
                            output framed_byte_t outs [bsf_pkg::MAX_RESULTS],
                            output int n);
    n = 0;
    if (!tb_open) begin
      outs[n] = '{tb_flag, 1'b0, 1'b0};
      tb_par ^= tb_flag;
      n++;
      tb_open = 1'b1;
    end
    if (d == tb_flag || d == tb_esc) begin
      outs[n] = '{tb_esc, 1'b0, 1'b0};
      tb_par ^= tb_esc;
      n++;
    end
    outs[n] = '{d, 1'b0, 1'b0};
    tb_par ^= d;
    n++;
    if (eom) begin
      outs[n] = '{tb_flag, 1'b0, 1'b0};
      tb_par ^= tb_flag;
      n++;
      outs[n] = '{tb_par, 1'b1, 1'b0};
      n++;
      tb_open = 1'b0;
      tb_par = '0;
    end
    outs[n-1].run_end = 1'b1;
  endtask

  // entered and left at a rising edge
  task automatic send_msg_byte(input logic [7:0] d, input logic eom,
                               input int n_exp, input logic [0:4][7:0] exp);
    framed_byte_t outs [bsf_pkg::MAX_RESULTS];
    framed_byte_t fb;
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= eom;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    frame_byte(d, eom, outs, n);
    if (n_exp > 0) begin
      for (int i = 0; i < n_exp; i++) begin
        fb = '{exp[i], eom && (i == n_exp - 1), i == n_exp - 1};
        framed_q.insert(framed_q.size(), fb);
      end
    end else begin
      for (int i = 0; i < n; i++) framed_q.insert(framed_q.size(), outs[i]);
    end
  endtask

  task automatic apb_write(input bsf_pkg::bsf_reg_t sel, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == bsf_pkg::REG_FLAG) tb_flag = v;
    else tb_esc = v;
  endtask

  task automatic drain_framer();
    s_tvalid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(7))
      0, 1:    return tb_flag;
      2, 3:    return tb_esc;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (framed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: byte %h trailer %b last %b",
                   m_tdata, m_tuser, m_tlast);
      end else begin
        got_exp = framed_q.pop_front();
        if (m_tdata !== got_exp.obyte || m_tuser !== got_exp.trailer ||
            m_tlast !== got_exp.run_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp byte %h trailer %b last %b, got %h %b %b",
                     got_exp.obyte, got_exp.trailer, got_exp.run_end,
                     m_tdata, m_tuser, m_tlast);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int cnt;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain_framer();
        apb_write(dir_rows[i].rsel, dir_rows[i].val);
      end else begin
        send_msg_byte(dir_rows[i].val, dir_rows[i].eom, dir_rows[i].n_exp,
                      dir_rows[i].exp);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_framer();
      case ($urandom_range(3))
        0: begin
          apb_write(bsf_pkg::REG_FLAG, 8'h00);
          apb_write(bsf_pkg::REG_ESCAPE, 8'hFF);
        end
        1: begin
          apb_write(bsf_pkg::REG_FLAG, 8'hFF);
          apb_write(bsf_pkg::REG_ESCAPE, 8'h00);
        end
        2: begin
          len = $urandom_range(255);
          apb_write(bsf_pkg::REG_FLAG, 8'(len));
          apb_write(bsf_pkg::REG_ESCAPE, 8'(len));
        end
        default: begin
          apb_write(bsf_pkg::REG_FLAG, 8'($urandom_range(255)));
          apb_write(bsf_pkg::REG_ESCAPE, 8'($urandom_range(255)));
        end
      endcase
      send_idle_pct = phase_idle[p];
      recv_stall_pct <= phase_stall[p];
      if (p == N_PHASES - 1) begin
        hold_len <= HOLD_CYCLES;
        hold_seq <= hold_seq + 1;
      end
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len && cnt < PHASE_ITEMS; j++) begin
          send_msg_byte(pick_data(), j == len - 1, 0, '0);
          cnt++;
        end
      end
    end

    drain_framer();
    if (mismatches == 0 && framed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
